[rtl/core/lfpg_pkg.sv]
// types and constants shared by the light flash pattern generator
package lfpg_pkg;

  localparam int MODE_W    = 4;
  localparam int PERIOD_W  = 10;
  localparam int GROUP_W   = 4;
  localparam int SLOT_W    = 7;
  localparam int NEED_W    = 6;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [GROUP_W-1:0]   group_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_FIXED  = 4'd1;
  localparam mode_t MODE_FLASH  = 4'd2;
  localparam mode_t MODE_LONG   = 4'd3;
  localparam mode_t MODE_QUICK  = 4'd4;
  localparam mode_t MODE_VQUICK = 4'd5;
  localparam mode_t MODE_ISO    = 4'd7;
  localparam mode_t MODE_OCCULT = 4'd8;

  localparam cfg_idx_t CFG_MODE   = 2'd0;
  localparam cfg_idx_t CFG_PERIOD = 2'd1;
  localparam cfg_idx_t CFG_GROUP  = 2'd2;

  localparam mode_t   RESET_MODE   = MODE_FLASH;
  localparam period_t RESET_PERIOD = 10'd0;
  localparam group_t  RESET_GROUP  = 4'd1;

  localparam period_t DEFAULT_PERIOD = 10'd16;
  localparam period_t MIN_PERIOD     = 10'd4;
  localparam group_t  MAX_GROUP      = 4'd9;
  localparam slot_t   LONG_MIN_LEN   = 7'd8;
  localparam slot_t   FLASH_SLOTS    = 7'd4;
  localparam slot_t   OCCULT_DARK    = 7'd4;

  typedef struct packed {
    mode_t   mode;
    period_t period;
    group_t  group;
  } lfpg_cfg_t;

  typedef struct packed {
    logic  lamp;
    slot_t slot;
    logic  last;
  } lfpg_tick_t;

endpackage

[rtl/core/lfpg_pattern.sv]
// cycle length and lamp pattern decode for one tick
module lfpg_pattern import lfpg_pkg::*; #(
  parameter int MAX_SLOTS = 100
) (
  input  lfpg_cfg_t  cfg,
  input  slot_t      slot_position,
  input  logic       restart,
  output lfpg_tick_t tick
);

  localparam period_t MAX_PERIOD = PERIOD_W'(MAX_SLOTS);

  group_t  n_eff;
  logic [NEED_W-1:0] need;
  period_t p;
  slot_t   len;
  slot_t   slot;

  always_comb begin
    n_eff = cfg.group;
    if (n_eff == '0) n_eff = group_t'(1);
    if (n_eff > MAX_GROUP) n_eff = MAX_GROUP;
    need = {n_eff, 2'b00} - NEED_W'(2);
  end

  always_comb begin
    p = cfg.period;
    if (p == '0) p = DEFAULT_PERIOD;
    if (p < MIN_PERIOD) p = MIN_PERIOD;
    if (p > MAX_PERIOD) p = MAX_PERIOD;
    len = p[SLOT_W-1:0];
    if (cfg.mode == MODE_FLASH && n_eff > group_t'(1) && len < SLOT_W'(need)) begin
      len = SLOT_W'(need);
    end
    if (cfg.mode == MODE_LONG && len < LONG_MIN_LEN) len = LONG_MIN_LEN;
  end

  // stale position after a register change behaves as a restart
  assign slot = (restart || slot_position >= len) ? '0 : slot_position;

  always_comb begin
    tick.slot = slot;
    tick.last = (slot == len - slot_t'(1));
    case (cfg.mode)
      MODE_FIXED:  tick.lamp = 1'b1;
      MODE_FLASH: begin
        if (n_eff == group_t'(1)) tick.lamp = (slot < FLASH_SLOTS);
        else tick.lamp = (slot < SLOT_W'(need)) && !slot[1];
      end
      MODE_LONG:   tick.lamp = (slot < LONG_MIN_LEN);
      MODE_QUICK:  tick.lamp = (slot[1:0] == 2'b00);
      MODE_VQUICK: tick.lamp = !slot[0];
      MODE_ISO:    tick.lamp = (slot < {1'b0, len[SLOT_W-1:1]});
      MODE_OCCULT: tick.lamp = (slot < len - OCCULT_DARK);
      default:     tick.lamp = (slot < FLASH_SLOTS);
    endcase
  end

endmodule

[rtl/core/light_flash_pattern_generator_unit.sv]
// light flash pattern generator: one lamp state item per tick item
// an accepted tick's result is in the output register in the next cycle
// throughput: one item per cycle while out_ready is high, set by the single slot counter update
// a waiting result stalls input only while out_ready is low
// rst is synchronous: counter to slot zero, config registers to their defaults, output empty
module light_flash_pattern_generator_unit import lfpg_pkg::*; #(
  parameter int MAX_SLOTS = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  cfg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 lamp_on,
  output logic [SLOT_W-1:0]    slot_index,
  output logic                 cycle_end
);

  lfpg_cfg_t  cfg;
  slot_t      slot_position;
  lfpg_tick_t tick;
  logic       in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= RESET_MODE;
      cfg.period <= RESET_PERIOD;
      cfg.group  <= RESET_GROUP;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE:   cfg.mode   <= cfg_data[MODE_W-1:0];
        CFG_PERIOD: cfg.period <= cfg_data[PERIOD_W-1:0];
        CFG_GROUP:  cfg.group  <= cfg_data[GROUP_W-1:0];
        default:    ;
      endcase
    end
  end

  lfpg_pattern #(.MAX_SLOTS(MAX_SLOTS)) u_pattern (
    .cfg           (cfg),
    .slot_position (slot_position),
    .restart       (restart),
    .tick          (tick)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        slot_position <= tick.last ? '0 : tick.slot + slot_t'(1);
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lamp_on    <= tick.lamp;
      slot_index <= tick.slot;
      cycle_end  <= tick.last;
    end
  end

`ifndef ASSERT_OFF
  a_wrap_to_zero: assert property (@(posedge clk) disable iff (rst)
    in_fire && tick.last |=> slot_position == '0)
    else $error("slot counter did not wrap after last slot");

  a_restart_slot: assert property (@(posedge clk) disable iff (rst)
    in_fire && restart |=> out_valid && slot_index == '0)
    else $error("restart item did not report slot zero");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire && !tick.last |=> slot_position == $past(tick.slot) + slot_t'(1))
    else $error("slot counter did not advance by one");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");
`endif

endmodule
